// ===== rtl/core/pivc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pivc_pkg
// Shared types and constants for the path intermediate vertex counter.
// ----------------------------------------------------------------------------
package pivc_pkg;

   localparam int CMD_W    = 2;
   localparam int VERTEX_W = 6;
   localparam int COUNT_W  = 6;
   localparam int CFG_W    = 7;

   localparam logic [CFG_W-1:0] NUM_VERTICES_RESET = 7'd64;

   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COUNT,
      ST_DELIVER
   } ctrl_state_type;

   typedef struct packed {
      logic                clear_all;
      logic                add_edge;
      logic                start;
      logic                clear_reach;
      logic                step;
      logic                count;
      logic [VERTEX_W-1:0] a;
      logic [VERTEX_W-1:0] b;
   } cell_ctl_type;

endpackage

// ===== rtl/core/pivc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pivc_req_if
// Command channel: clear, add edge or query, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pivc_req_if;

   logic                          valid;
   logic                          ready;
   logic [pivc_pkg::CMD_W-1:0]    cmd;
   logic [pivc_pkg::VERTEX_W-1:0] from_vertex;
   logic [pivc_pkg::VERTEX_W-1:0] to_vertex;

   modport source (output valid, output cmd, output from_vertex, output to_vertex,
                   input ready);
   modport sink   (input valid, input cmd, input from_vertex, input to_vertex,
                   output ready);

endinterface

// ===== rtl/core/pivc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pivc_rsp_if
// Query result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pivc_rsp_if;

   logic                         valid;
   logic                         ready;
   logic [pivc_pkg::COUNT_W-1:0] intermediate_count;
   logic                         impossible;

   modport source (output valid, output intermediate_count, output impossible,
                   input ready);
   modport sink   (input valid, input intermediate_count, input impossible,
                   output ready);

endinterface

// ===== rtl/core/path_intermediate_vertex_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_intermediate_vertex_counter
// Directed graph store that counts vertices lying on source-to-target paths.
// ----------------------------------------------------------------------------
// usage:
//   req_bus carries clear (0), add edge (1) and query (2) transactions;
//   rsp_bus returns one transaction per query, none for other commands.
//   csr_wr_en/csr_wr_data set num_vertices; the user must write them only
//   while the block is idle, which the block itself does not enforce.
// sequencing:
//   clear and add edge are taken back to back while no query is in flight.
//   a query is accepted, then searches one breadth-first level per cycle in
//   all cells at once until no reach bit changes, then popcounts through
//   the cell chain and loads the output register, raising rsp_bus.valid.
//   out-of-range queries skip the search and the popcount.
// reset:
//   empties both adjacency matrices and reach sets, num_vertices = 64.
// stall:
//   a result waits in the output register; a new command is still taken,
//   and a second query result holds in the sequencer until the first leaves.
// ----------------------------------------------------------------------------
module path_intermediate_vertex_counter #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [pivc_pkg::CFG_W-1:0] csr_wr_data,
   pivc_req_if.sink                   req_bus,
   pivc_rsp_if.source                 rsp_bus
);
   import pivc_pkg::*;

   localparam int SUM_W = $clog2(MAX_VERTICES + 1);

   logic [CFG_W-1:0]        num_vertices_ff, num_vertices_in;
   logic [MAX_VERTICES-1:0] vmask;
   logic [MAX_VERTICES-1:0] fr_vec, br_vec, chg_vec;
   logic [SUM_W-1:0]        sum_vec [MAX_VERTICES];
   logic                    any_changed;
   cell_ctl_type            cell_ctl;

   assign num_vertices_in = csr_wr_en ? csr_wr_data : num_vertices_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vertices_ff <= NUM_VERTICES_RESET;
      end else begin
         num_vertices_ff <= num_vertices_in;
      end
   end

   assign any_changed = |chg_vec;

   pivc_ctrl #(
      .NUM (MAX_VERTICES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .num_vertices (num_vertices_ff),
      .any_changed  (any_changed),
      .total        (sum_vec[MAX_VERTICES-1]),
      .vmask        (vmask),
      .ctl          (cell_ctl),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus)
   );

   for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
      logic [SUM_W-1:0] chain_in;
      if (i == 0) begin : g_head
         assign chain_in = '0;
      end else begin : g_link
         assign chain_in = sum_vec[i-1];
      end
      pivc_cell #(
         .INDEX (i),
         .NUM   (MAX_VERTICES)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (cell_ctl),
         .active  (vmask[i]),
         .fr_vec  (fr_vec),
         .br_vec  (br_vec),
         .sum_in  (chain_in),
         .fr_out  (fr_vec[i]),
         .br_out  (br_vec[i]),
         .changed (chg_vec[i]),
         .sum_out (sum_vec[i])
      );
   end

`ifndef SYNTHESIS
   a_single_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cell_ctl.clear_all, cell_ctl.add_edge, cell_ctl.start,
                cell_ctl.clear_reach, cell_ctl.step, cell_ctl.count}))
      else $error("more than one cell operation in a cycle");

   a_start_on_transaction: assert property (@(posedge clock) disable iff (reset)
      cell_ctl.start |-> req_bus.valid && req_bus.ready)
      else $error("search started without a request transaction");

   a_count_after_settle: assert property (@(posedge clock) disable iff (reset)
      $rose(cell_ctl.count) |-> $past(cell_ctl.step) && !$past(any_changed))
      else $error("popcount started before reach sets settled");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> $past(sum_vec[MAX_VERTICES-1]) < SUM_W'(MAX_VERTICES)
                        || $past(rsp_bus.valid))
      else $error("intermediate count out of range");
`endif

endmodule

// ===== rtl/core/pivc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pivc_cell
// One vertex: its outgoing and incoming adjacency rows, its forward and
// backward reach bits, and one stage of the popcount chain.
// ----------------------------------------------------------------------------
module pivc_cell #(
   parameter int INDEX = 0,
   parameter int NUM   = 64,
   localparam int SUM_W = $clog2(NUM + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pivc_pkg::cell_ctl_type ctl,
   input  logic                   active,
   input  logic [NUM-1:0]         fr_vec,
   input  logic [NUM-1:0]         br_vec,
   input  logic [SUM_W-1:0]       sum_in,
   output logic                   fr_out,
   output logic                   br_out,
   output logic                   changed,
   output logic [SUM_W-1:0]       sum_out
);
   import pivc_pkg::*;

   logic [NUM-1:0]   fwd_row_ff, fwd_row_in;
   logic [NUM-1:0]   rev_row_ff, rev_row_in;
   logic             fr_ff, fr_in;
   logic             br_ff, br_in;
   logic [SUM_W-1:0] sum_ff, sum_in_nxt;
   logic [NUM-1:0]   dec_a, dec_b;
   logic             fr_step, br_step, both;

   localparam logic [VERTEX_W-1:0] MY_ID = VERTEX_W'(INDEX);

   always_comb begin
      for (int k = 0; k < NUM; k++) begin
         dec_a[k] = (ctl.a == VERTEX_W'(k));
         dec_b[k] = (ctl.b == VERTEX_W'(k));
      end
      fr_step = fr_ff | (active & (|(rev_row_ff & fr_vec)));
      br_step = br_ff | (active & (|(fwd_row_ff & br_vec)));
      both    = fr_ff & br_ff & active & (ctl.a != MY_ID) & (ctl.b != MY_ID);

      fwd_row_in = fwd_row_ff;
      rev_row_in = rev_row_ff;
      fr_in      = fr_ff;
      br_in      = br_ff;
      sum_in_nxt = sum_ff;
      changed    = 1'b0;

      priority if (ctl.clear_all) begin
         fwd_row_in = '0;
         rev_row_in = '0;
         fr_in      = 1'b0;
         br_in      = 1'b0;
      end else if (ctl.add_edge) begin
         if (ctl.a == MY_ID) fwd_row_in = fwd_row_ff | dec_b;
         if (ctl.b == MY_ID) rev_row_in = rev_row_ff | dec_a;
      end else if (ctl.start) begin
         fr_in      = (ctl.a == MY_ID);
         br_in      = (ctl.b == MY_ID);
         sum_in_nxt = '0;
      end else if (ctl.clear_reach) begin
         fr_in = 1'b0;
         br_in = 1'b0;
      end else if (ctl.step) begin
         fr_in   = fr_step;
         br_in   = br_step;
         changed = (fr_step != fr_ff) | (br_step != br_ff);
      end else if (ctl.count) begin
         sum_in_nxt = sum_in + {{(SUM_W-1){1'b0}}, both};
      end else begin
         // idle cycle, hold everything
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_row_ff <= '0;
         rev_row_ff <= '0;
         fr_ff      <= 1'b0;
         br_ff      <= 1'b0;
         sum_ff     <= '0;
      end else begin
         fwd_row_ff <= fwd_row_in;
         rev_row_ff <= rev_row_in;
         fr_ff      <= fr_in;
         br_ff      <= br_in;
         sum_ff     <= sum_in_nxt;
      end
   end

   assign fr_out  = fr_ff;
   assign br_out  = br_ff;
   assign sum_out = sum_ff;

endmodule

// ===== rtl/core/pivc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pivc_ctrl
// Command decode, search/count sequencer and result output register.
// ----------------------------------------------------------------------------
module pivc_ctrl #(
   parameter int NUM = 64,
   localparam int SUM_W = $clog2(NUM + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pivc_pkg::CFG_W-1:0]  num_vertices,
   input  logic                        any_changed,
   input  logic [SUM_W-1:0]            total,
   output logic [NUM-1:0]              vmask,
   output pivc_pkg::cell_ctl_type      ctl,
   pivc_req_if.sink                    req_bus,
   pivc_rsp_if.source                  rsp_bus
);
   import pivc_pkg::*;

   localparam int CNT_W = $clog2(NUM);

   ctrl_state_type      state_ff, state_in;
   logic [VERTEX_W-1:0] a_ff, a_in;
   logic [VERTEX_W-1:0] b_ff, b_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                oor_ff, oor_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_imp_ff, rsp_imp_in;
   logic [CFG_W-1:0]    n_eff;
   logic                accept, from_ok, to_ok;

   always_comb begin
      if (num_vertices == '0)
         n_eff = CFG_W'(1);
      else if (num_vertices > CFG_W'(NUM))
         n_eff = CFG_W'(NUM);
      else
         n_eff = num_vertices;
      for (int j = 0; j < NUM; j++)
         vmask[j] = (CFG_W'(j) < n_eff);
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept  = req_bus.valid && req_bus.ready;
   assign from_ok = ({1'b0, req_bus.from_vertex} < n_eff);
   assign to_ok   = ({1'b0, req_bus.to_vertex} < n_eff);

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      cnt_in       = cnt_ff;
      oor_in       = oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_count_in = rsp_count_ff;
      rsp_imp_in   = rsp_imp_ff;

      ctl             = '0;
      ctl.a           = (state_ff == ST_IDLE) ? req_bus.from_vertex : a_ff;
      ctl.b           = (state_ff == ST_IDLE) ? req_bus.to_vertex : b_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in = req_bus.from_vertex;
               b_in = req_bus.to_vertex;
               unique case (req_bus.cmd)
                  CMD_CLEAR: begin
                     ctl.clear_all = 1'b1;
                  end
                  CMD_ADD_EDGE: begin
                     ctl.add_edge = from_ok && to_ok;
                  end
                  CMD_QUERY: begin
                     if (from_ok && to_ok) begin
                        ctl.start = 1'b1;
                        oor_in    = 1'b0;
                        state_in  = ST_SEARCH;
                     end else begin
                        ctl.clear_reach = 1'b1;
                        oor_in          = 1'b1;
                        state_in        = ST_DELIVER;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            ctl.step = 1'b1;
            if (!any_changed) begin
               cnt_in   = '0;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            ctl.count = 1'b1;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM - 1))
               state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = oor_ff ? '0 : COUNT_W'(total);
               rsp_imp_in   = oor_ff || (total == '0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         oor_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         oor_ff       <= oor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      rsp_count_ff <= rsp_count_in;
      rsp_imp_ff   <= rsp_imp_in;
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.intermediate_count = rsp_count_ff;
   assign rsp_bus.impossible         = rsp_imp_ff;

endmodule

// ===== tb/sv/path_intermediate_vertex_counter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_intermediate_vertex_counter_test
// Self-checking bench for the path intermediate vertex counter. A directed
// table covers reset state, the vertex-count extremes, out-of-range edges and
// queries, clears and source-equals-target loops. Random phases then build
// random graphs, chains and rings under several vertex counts and idle/stall
// profiles. Query results are checked against a reachability model or table.
// ----------------------------------------------------------------------------
module path_intermediate_vertex_counter_test;
   import pivc_pkg::*;

   localparam int NUM_SLOTS     = 64;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 250;
   localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 12;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int MAX_REPORTS   = 10;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int SEND_IDLE_PCT [4] = '{0, 80, 0, 23};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 80, 23};
   localparam logic [CFG_W-1:0] PHASE_LIMITS [NUM_PHASES] =
      '{7'd64, 7'd127, 7'd2, 7'd37, 7'd0, 7'd64, 7'd12, 7'd100};

   typedef enum logic {ROW_REQUEST, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [CMD_W-1:0]    cmd;
      logic [VERTEX_W-1:0] from_vertex;
      logic [VERTEX_W-1:0] to_vertex;
      logic [CFG_W-1:0]    csr_value;
      logic                typed;
      logic [COUNT_W-1:0]  count;
      logic                impossible;
   } directed_row_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               impossible;
   } path_count_type;

   localparam int NUM_ROWS = 26;
   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{ROW_REQUEST, CMD_QUERY,    6'd0,  6'd63, 7'd0,   1'b1, 6'd0, 1'b1},
      '{ROW_REQUEST, CMD_QUERY,    6'd63, 6'd63, 7'd0,   1'b1, 6'd0, 1'b1},
      '{ROW_REQUEST, CMD_ADD_EDGE, 6'd0,  6'd1,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_ADD_EDGE, 6'd1,  6'd2,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_ADD_EDGE, 6'd2,  6'd63, 7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_ADD_EDGE, 6'd63, 6'd0,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_QUERY,    6'd0,  6'd63, 7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_QUERY,    6'd0,  6'd0,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_UNUSED,   6'd63, 6'd63, 7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_CSR,     CMD_CLEAR,    6'd0,  6'd0,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_QUERY,    6'd0,  6'd0,  7'd0,   1'b1, 6'd0, 1'b1},
      '{ROW_REQUEST, CMD_QUERY,    6'd1,  6'd0,  7'd0,   1'b1, 6'd0, 1'b1},
      '{ROW_REQUEST, CMD_ADD_EDGE, 6'd0,  6'd1,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_CSR,     CMD_CLEAR,    6'd0,  6'd0,  7'd3,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_QUERY,    6'd0,  6'd2,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_ADD_EDGE, 6'd5,  6'd1,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_QUERY,    6'd0,  6'd63, 7'd0,   1'b1, 6'd0, 1'b1},
      '{ROW_CSR,     CMD_CLEAR,    6'd0,  6'd0,  7'd127, 1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_QUERY,    6'd63, 6'd2,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_CLEAR,    6'd63, 6'd63, 7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_QUERY,    6'd0,  6'd63, 7'd0,   1'b1, 6'd0, 1'b1},
      '{ROW_CSR,     CMD_CLEAR,    6'd0,  6'd0,  7'd2,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_ADD_EDGE, 6'd0,  6'd1,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_ADD_EDGE, 6'd1,  6'd0,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_REQUEST, CMD_QUERY,    6'd1,  6'd1,  7'd0,   1'b0, 6'd0, 1'b0},
      '{ROW_CSR,     CMD_CLEAR,    6'd0,  6'd0,  7'd64,  1'b0, 6'd0, 1'b0}
   };

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   pivc_req_if req_bus ();
   pivc_rsp_if rsp_bus ();

   path_intermediate_vertex_counter #(
      .MAX_VERTICES(NUM_SLOTS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus)
   );

   logic [NUM_SLOTS-1:0] fwd_rows [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] rev_rows [NUM_SLOTS];
   logic [CFG_W-1:0]     vertex_limit;
   path_count_type       pending_counts [$];
   path_count_type       oldest_count;

   int idle_pct        = 0;
   int stall_pct       = 0;
   int failures        = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int impossible_seen = 0;
   int max_count_seen  = 0;
   int cycle_count     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_counts.size());
      $display("TEST FAILED");
      $finish;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_counts.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("unexpected result: count %0d impossible %0b",
                        rsp_bus.intermediate_count, rsp_bus.impossible);
            end
         end else begin
            oldest_count = pending_counts.pop_front();
            results_checked++;
            if (rsp_bus.intermediate_count !== oldest_count.count ||
                rsp_bus.impossible !== oldest_count.impossible) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display("result %0d mismatch: expected count %0d impossible %0b, got %0d %0b",
                           results_checked, oldest_count.count, oldest_count.impossible,
                           rsp_bus.intermediate_count, rsp_bus.impossible);
               end
            end
            if (oldest_count.impossible) impossible_seen++;
            if (int'(oldest_count.count) > max_count_seen) begin
               max_count_seen = int'(oldest_count.count);
            end
         end
      end
   end

   function automatic int active_vertices();
      if (vertex_limit == '0) return 1;
      if (int'(vertex_limit) > NUM_SLOTS) return NUM_SLOTS;
      return int'(vertex_limit);
   endfunction

   function automatic logic [NUM_SLOTS-1:0] vertex_mask(input int n);
      if (n >= NUM_SLOTS) return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   function automatic logic [NUM_SLOTS-1:0] reach_set(input logic backward, input int start,
                                                      input logic [NUM_SLOTS-1:0] vmask);
      logic [NUM_SLOTS-1:0] reached;
      logic [NUM_SLOTS-1:0] grown;
      reached = 64'd1 << start;
      do begin
         grown = reached;
         for (int v = 0; v < NUM_SLOTS; v++) begin
            if (grown[v]) reached |= (backward ? rev_rows[v] : fwd_rows[v]) & vmask;
         end
      end while (reached != grown);
      return reached;
   endfunction

   function automatic path_count_type predict_path_count(input int src, input int dst);
      int                   n;
      logic [NUM_SLOTS-1:0] vmask;
      logic [NUM_SLOTS-1:0] on_path;
      path_count_type       r;
      n = active_vertices();
      vmask = vertex_mask(n);
      r.count = '0;
      r.impossible = 1'b1;
      if (src >= n || dst >= n) return r;
      on_path = reach_set(1'b0, src, vmask) & reach_set(1'b1, dst, vmask) & vmask;
      on_path[src] = 1'b0;
      on_path[dst] = 1'b0;
      r.count = COUNT_W'($countones(on_path));
      r.impossible = (on_path == '0);
      return r;
   endfunction

   function automatic void apply_request(input logic [CMD_W-1:0] cmd,
                                         input logic [VERTEX_W-1:0] src,
                                         input logic [VERTEX_W-1:0] dst,
                                         input logic typed,
                                         input path_count_type typed_result);
      int n;
      int s;
      int d;
      n = active_vertices();
      s = int'(src);
      d = int'(dst);
      case (cmd)
         CMD_CLEAR: begin
            for (int v = 0; v < NUM_SLOTS; v++) begin
               fwd_rows[v] = '0;
               rev_rows[v] = '0;
            end
            items_sent++;
         end
         CMD_ADD_EDGE: begin
            if (s < n && d < n) begin
               fwd_rows[s][d] = 1'b1;
               rev_rows[d][s] = 1'b1;
               items_sent++;
            end
         end
         CMD_QUERY: begin
            pending_counts.push_back(typed ? typed_result : predict_path_count(s, d));
            items_sent++;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [VERTEX_W-1:0] src,
                               input logic [VERTEX_W-1:0] dst,
                               input logic typed = 1'b0,
                               input path_count_type typed_result = '0);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= cmd;
      req_bus.from_vertex <= src;
      req_bus.to_vertex   <= dst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_request(cmd, src, dst, typed, typed_result);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   task automatic write_vertex_limit(input logic [CFG_W-1:0] value);
      drain_results();
      // adds and clears leave no result, so give the sequencer time to settle
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      vertex_limit = value;
   endtask

   function automatic logic [VERTEX_W-1:0] pick_vertex(input int n);
      if ($urandom_range(99) < 10) return VERTEX_W'($urandom_range(NUM_SLOTS - 1));
      return VERTEX_W'($urandom_range(n - 1));
   endfunction

   task automatic run_random_phase(input int quota);
      int                  first;
      int                  n;
      int                  kind;
      int                  len;
      int                  pick;
      int                  tmp;
      logic [VERTEX_W-1:0] src;
      int                  order [NUM_SLOTS];
      first = items_sent;
      while (items_sent - first < quota) begin
         n = active_vertices();
         kind = $urandom_range(99);
         if (kind < 55) begin
            // random graph, then a burst of queries
            if ($urandom_range(99) < 70) begin
               send_request(CMD_CLEAR, pick_vertex(n), pick_vertex(n));
            end
            repeat ($urandom_range(2 * n)) send_request(CMD_ADD_EDGE, pick_vertex(n),
                                                        pick_vertex(n));
            repeat ($urandom_range(1, 6)) begin
               src = pick_vertex(n);
               send_request(CMD_QUERY, src, ($urandom_range(99) < 10) ? src : pick_vertex(n));
            end
         end else if (kind < 70 && n >= 2) begin
            // chain or ring over a shuffled vertex order
            for (int i = 0; i < n; i++) order[i] = i;
            for (int i = n - 1; i > 0; i--) begin
               pick = $urandom_range(i);
               tmp = order[i];
               order[i] = order[pick];
               order[pick] = tmp;
            end
            len = ($urandom_range(3) == 0) ? n : $urandom_range(2, n);
            send_request(CMD_CLEAR, pick_vertex(n), pick_vertex(n));
            for (int i = 0; i + 1 < len; i++) begin
               send_request(CMD_ADD_EDGE, VERTEX_W'(order[i]), VERTEX_W'(order[i + 1]));
            end
            if ($urandom_range(1) == 1) begin
               send_request(CMD_ADD_EDGE, VERTEX_W'(order[len - 1]), VERTEX_W'(order[0]));
            end
            send_request(CMD_QUERY, VERTEX_W'(order[0]), VERTEX_W'(order[len - 1]));
            send_request(CMD_QUERY, VERTEX_W'(order[0]), VERTEX_W'(order[0]));
            send_request(CMD_QUERY, VERTEX_W'(order[len - 1]), VERTEX_W'(order[0]));
         end else if (kind < 85) begin
            repeat ($urandom_range(1, 6)) begin
               send_request(CMD_W'($urandom_range(3)), VERTEX_W'($urandom_range(63)),
                            VERTEX_W'($urandom_range(63)));
            end
         end else begin
            // hold off until every pending result is back
            drain_results();
         end
      end
   endtask

   initial begin
      directed_row_type row;
      path_count_type   typed_result;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.cmd         = CMD_CLEAR;
      req_bus.from_vertex = '0;
      req_bus.to_vertex   = '0;
      rsp_bus.ready       = 1'b0;
      vertex_limit        = NUM_VERTICES_RESET;
      for (int v = 0; v < NUM_SLOTS; v++) begin
         fwd_rows[v] = '0;
         rev_rows[v] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_CSR) begin
            write_vertex_limit(row.csr_value);
         end else begin
            typed_result.count      = row.count;
            typed_result.impossible = row.impossible;
            send_request(row.cmd, row.from_vertex, row.to_vertex, row.typed, typed_result);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         write_vertex_limit(PHASE_LIMITS[phase]);
         idle_pct  = SEND_IDLE_PCT[phase % 4];
         stall_pct = RECV_STALL_PCT[phase % 4];
         run_random_phase(PHASE_ITEMS);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d effective transactions sent over %0d cycles and %0d vertex-count settings",
               items_sent, cycle_count, NUM_PHASES + 5);
      $display("%0d query results checked, %0d impossible, largest count %0d, %0d mismatches",
               results_checked, impossible_seen, max_count_seen, failures);
      if (failures == 0 && pending_counts.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
